// ----- hdl/pocx_pkg.sv -----
// ----------------------------------------------------------------------------
// pocx_pkg
// shared constants, types and helpers of the order crossover block
// ----------------------------------------------------------------------------
package pocx_pkg;

   localparam int MAX_JOBS = 64;
   localparam int JOB_W    = $clog2(MAX_JOBS);
   localparam int CNT_W    = $clog2(MAX_JOBS + 1);

   typedef logic [JOB_W-1:0] job_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      job_type parent_a_job;
      job_type parent_b_job;
      job_type seg_start;
      job_type seg_length;
      logic    last_element;
   } req_word_type;

   typedef struct packed {
      job_type child_a_job;
      job_type child_b_job;
      logic    last_result;
   } rsp_word_type;

   // classified word passed from front to back
   typedef struct packed {
      logic    store;
      job_type addr;
      job_type a_job;
      job_type b_job;
      logic    last;
      job_type start;
      job_type len;
      cnt_type first;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEG,
      ST_FILL,
      ST_DRAIN,
      ST_EMIT
   } back_state_type;

   localparam cnt_type RESET_JOBS = cnt_type'(MAX_JOBS);

   function automatic cnt_type eff_jobs(input cnt_type num_jobs);
      cnt_type n;
      if (num_jobs == '0) begin
         n = cnt_type'(1);
      end else if (num_jobs > cnt_type'(MAX_JOBS)) begin
         n = cnt_type'(MAX_JOBS);
      end else begin
         n = num_jobs;
      end
      return n;
   endfunction

endpackage

// ----- hdl/pocx_if.sv -----
// ----------------------------------------------------------------------------
// pocx_if
// valid/ready channels for parent words and child words
// ----------------------------------------------------------------------------
interface pocx_req_if;
   logic                  valid;
   logic                  ready;
   pocx_pkg::req_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface pocx_rsp_if;
   logic                  valid;
   logic                  ready;
   pocx_pkg::rsp_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/pocx_queue.sv -----
// ----------------------------------------------------------------------------
// pocx_queue
// two-word queue between front and back
// ----------------------------------------------------------------------------
module pocx_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  pocx_pkg::cmd_type push_word,
   output logic              pop_valid,
   input  logic              pop_ready,
   output pocx_pkg::cmd_type pop_word
);

   pocx_pkg::cmd_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_word   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ----- hdl/pocx_front.sv -----
// ----------------------------------------------------------------------------
// pocx_front
// takes parent words, tracks load position and clips the segment
// ----------------------------------------------------------------------------
module pocx_front (
   input  logic               clock,
   input  logic               reset,
   input  pocx_pkg::cnt_type  n_jobs,
   pocx_req_if.sink           req_chan,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output pocx_pkg::cmd_type  cmd
);

   pocx_pkg::cnt_type load_count_ff, load_count_in;
   pocx_pkg::cnt_type start_w, start_c, len_w, sum_w, len_c;
   logic              accept;

   assign req_chan.ready = cmd_ready;
   assign cmd_valid      = req_chan.valid;
   assign accept         = req_chan.valid && cmd_ready;

   always_comb begin
      start_w = {1'b0, req_chan.payload.seg_start};
      len_w   = {1'b0, req_chan.payload.seg_length};
      start_c = (start_w >= n_jobs) ? (n_jobs - pocx_pkg::cnt_type'(1)) : start_w;
      sum_w   = start_c + len_w;
      len_c   = (sum_w > n_jobs) ? (n_jobs - start_c) : len_w;

      cmd.store = (load_count_ff < n_jobs);
      cmd.addr  = load_count_ff[pocx_pkg::JOB_W-1:0];
      cmd.a_job = req_chan.payload.parent_a_job;
      cmd.b_job = req_chan.payload.parent_b_job;
      cmd.last  = req_chan.payload.last_element;
      cmd.start = start_c[pocx_pkg::JOB_W-1:0];
      cmd.len   = len_c[pocx_pkg::JOB_W-1:0];
      cmd.first = start_c + len_c;
   end

   always_comb begin
      load_count_in = load_count_ff;
      if (accept) begin
         if (req_chan.payload.last_element) begin
            load_count_in = '0;
         end else if (load_count_ff < pocx_pkg::cnt_type'(pocx_pkg::MAX_JOBS)) begin
            load_count_in = load_count_ff + pocx_pkg::cnt_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
      end else begin
         load_count_ff <= load_count_in;
      end
   end

endmodule

// ----- hdl/pocx_back.sv -----
// ----------------------------------------------------------------------------
// pocx_back
// parent stores, segment copy, fill scan and child word output
// ----------------------------------------------------------------------------
module pocx_back (
   input  logic               clock,
   input  logic               reset,
   input  pocx_pkg::cnt_type  n_jobs,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  pocx_pkg::cmd_type  cmd,
   pocx_rsp_if.source         rsp_chan
);

   localparam int NJ = pocx_pkg::MAX_JOBS;
   localparam int JW = pocx_pkg::JOB_W;

   pocx_pkg::back_state_type state_ff, state_in;

   pocx_pkg::job_type pa_mem [NJ];
   pocx_pkg::job_type pb_mem [NJ];
   pocx_pkg::job_type ca_mem [NJ];
   pocx_pkg::job_type cb_mem [NJ];

   pocx_pkg::job_type pa_rd_ff, pb_rd_ff, ca_rd_ff, cb_rd_ff;
   logic              wa_bit_ff, wb_bit_ff, last_ff;

   pocx_pkg::job_type idx_ff, idx_in;
   pocx_pkg::cnt_type first_ff, first_in;
   pocx_pkg::job_type pos_a_ff, pos_a_in, pos_b_ff, pos_b_in;
   pocx_pkg::job_type pend_addr_ff, pend_addr_in;
   logic              pend_seg_ff, pend_seg_in, pend_fill_ff, pend_fill_in;
   logic [NJ-1:0]     used_a_ff, used_a_in, used_b_ff, used_b_in;
   logic [NJ-1:0]     wr_a_ff, wr_a_in, wr_b_ff, wr_b_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              pop, rd_en, take_a, take_b, seg_done;
   logic              ca_we, cb_we;
   pocx_pkg::job_type ca_waddr, cb_waddr, ca_wdata, cb_wdata, nm1;

   assign nm1       = JW'(n_jobs - pocx_pkg::cnt_type'(1));
   assign cmd_ready = (state_ff == pocx_pkg::ST_IDLE);
   assign pop       = cmd_valid && cmd_ready;
   assign rd_en     = (state_ff == pocx_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_chan.ready);
   assign seg_done  = ({1'b0, idx_ff} + pocx_pkg::cnt_type'(1)) == first_ff;
   assign take_a    = pend_fill_ff && !used_a_ff[pb_rd_ff];
   assign take_b    = pend_fill_ff && !used_b_ff[pa_rd_ff];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pocx_pkg::ST_IDLE: begin
            if (pop && cmd.last) begin
               state_in = (cmd.len != '0) ? pocx_pkg::ST_SEG : pocx_pkg::ST_FILL;
            end
         end
         pocx_pkg::ST_SEG: begin
            if (seg_done) begin
               state_in = pocx_pkg::ST_FILL;
            end
         end
         pocx_pkg::ST_FILL: begin
            if (idx_ff == nm1) begin
               state_in = pocx_pkg::ST_DRAIN;
            end
         end
         pocx_pkg::ST_DRAIN: begin
            state_in = pocx_pkg::ST_EMIT;
         end
         pocx_pkg::ST_EMIT: begin
            if (rd_en && idx_ff == nm1) begin
               state_in = pocx_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pocx_pkg::ST_IDLE;
         end
      endcase
   end

   // counters and control outputs
   always_comb begin
      idx_in       = idx_ff;
      first_in     = first_ff;
      pend_seg_in  = 1'b0;
      pend_fill_in = 1'b0;
      pend_addr_in = idx_ff;
      case (state_ff)
         pocx_pkg::ST_IDLE: begin
            if (pop && cmd.last) begin
               first_in = cmd.first;
               idx_in   = (cmd.len != '0) ? cmd.start : '0;
            end
         end
         pocx_pkg::ST_SEG: begin
            pend_seg_in = 1'b1;
            idx_in      = seg_done ? '0 : idx_ff + JW'(1);
         end
         pocx_pkg::ST_FILL: begin
            pend_fill_in = 1'b1;
            idx_in       = (idx_ff == nm1) ? '0 : idx_ff + JW'(1);
         end
         pocx_pkg::ST_DRAIN: begin
            idx_in = '0;
         end
         pocx_pkg::ST_EMIT: begin
            if (rd_en) begin
               idx_in = idx_ff + JW'(1);
            end
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   // segment copy and fill writes
   always_comb begin
      used_a_in = used_a_ff;
      used_b_in = used_b_ff;
      wr_a_in   = wr_a_ff;
      wr_b_in   = wr_b_ff;
      pos_a_in  = pos_a_ff;
      pos_b_in  = pos_b_ff;
      ca_we     = 1'b0;
      cb_we     = 1'b0;
      ca_waddr  = pos_a_ff;
      cb_waddr  = pos_b_ff;
      ca_wdata  = pb_rd_ff;
      cb_wdata  = pa_rd_ff;
      if (pop && cmd.last) begin
         used_a_in = '0;
         used_b_in = '0;
         wr_a_in   = '0;
         wr_b_in   = '0;
         pos_a_in  = (cmd.first == n_jobs) ? '0 : cmd.first[JW-1:0];
         pos_b_in  = (cmd.first == n_jobs) ? '0 : cmd.first[JW-1:0];
      end
      if (pend_seg_ff) begin
         ca_we                   = 1'b1;
         cb_we                   = 1'b1;
         ca_waddr                = pend_addr_ff;
         cb_waddr                = pend_addr_ff;
         ca_wdata                = pa_rd_ff;
         cb_wdata                = pb_rd_ff;
         used_a_in[pa_rd_ff]     = 1'b1;
         used_b_in[pb_rd_ff]     = 1'b1;
         wr_a_in[pend_addr_ff]   = 1'b1;
         wr_b_in[pend_addr_ff]   = 1'b1;
      end
      if (take_a) begin
         ca_we               = 1'b1;
         used_a_in[pb_rd_ff] = 1'b1;
         wr_a_in[pos_a_ff]   = 1'b1;
         pos_a_in            = (pos_a_ff == nm1) ? '0 : pos_a_ff + JW'(1);
      end
      if (take_b) begin
         cb_we               = 1'b1;
         used_b_in[pa_rd_ff] = 1'b1;
         wr_b_in[pos_b_ff]   = 1'b1;
         pos_b_in            = (pos_b_ff == nm1) ? '0 : pos_b_ff + JW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rd_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pocx_pkg::ST_IDLE;
         idx_ff       <= '0;
         first_ff     <= '0;
         pos_a_ff     <= '0;
         pos_b_ff     <= '0;
         pend_seg_ff  <= 1'b0;
         pend_fill_ff <= 1'b0;
         used_a_ff    <= '0;
         used_b_ff    <= '0;
         wr_a_ff      <= '0;
         wr_b_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         first_ff     <= first_in;
         pos_a_ff     <= pos_a_in;
         pos_b_ff     <= pos_b_in;
         pend_seg_ff  <= pend_seg_in;
         pend_fill_ff <= pend_fill_in;
         used_a_ff    <= used_a_in;
         used_b_ff    <= used_b_in;
         wr_a_ff      <= wr_a_in;
         wr_b_ff      <= wr_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
   end

   // parent stores
   always_ff @(posedge clock) begin
      if (pop && cmd.store) begin
         pa_mem[cmd.addr] <= cmd.a_job;
         pb_mem[cmd.addr] <= cmd.b_job;
      end
      pa_rd_ff <= pa_mem[idx_ff];
      pb_rd_ff <= pb_mem[idx_ff];
   end

   // child stores, read side is the output register
   always_ff @(posedge clock) begin
      if (ca_we) begin
         ca_mem[ca_waddr] <= ca_wdata;
      end
      if (cb_we) begin
         cb_mem[cb_waddr] <= cb_wdata;
      end
      if (rd_en) begin
         ca_rd_ff  <= ca_mem[idx_ff];
         cb_rd_ff  <= cb_mem[idx_ff];
         wa_bit_ff <= wr_a_ff[idx_ff];
         wb_bit_ff <= wr_b_ff[idx_ff];
         last_ff   <= (idx_ff == nm1);
      end
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.payload.child_a_job = wa_bit_ff ? ca_rd_ff : '0;
   assign rsp_chan.payload.child_b_job = wb_bit_ff ? cb_rd_ff : '0;
   assign rsp_chan.payload.last_result = last_ff;

endmodule

// ----- hdl/permutation_order_crossover.sv -----
// ----------------------------------------------------------------------------
// permutation_order_crossover
// order crossover of two job permutations, one parent position per word in
// ----------------------------------------------------------------------------
// Parent words are taken at one per cycle into a two-word queue and written
// into the parent stores; the word marked last starts a crossover, during
// which input stalls once the queue is full. A crossover runs the segment copy
// over the clipped segment and the fill scan over all n positions (one
// parent-store read per cycle, both children in parallel), then sends n child
// words at up to one per cycle. Stores need no clearing pass after reset;
// num_jobs must only be written while the block is idle.
module permutation_order_crossover (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [pocx_pkg::CNT_W-1:0] csr_wdata,
   pocx_req_if.sink                 req_chan,
   pocx_rsp_if.source               rsp_chan
);

   pocx_pkg::cnt_type num_jobs_ff, num_jobs_in, n_jobs;
   pocx_pkg::cmd_type front_cmd, back_cmd;
   logic              front_valid, front_ready, cmd_valid, cmd_ready;

   assign num_jobs_in = csr_we ? csr_wdata : num_jobs_ff;
   assign n_jobs      = pocx_pkg::eff_jobs(num_jobs_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         num_jobs_ff <= pocx_pkg::RESET_JOBS;
      end else begin
         num_jobs_ff <= num_jobs_in;
      end
   end

   pocx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .n_jobs    (n_jobs),
      .req_chan  (req_chan),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd       (front_cmd)
   );

   pocx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_word  (front_cmd),
      .pop_valid  (cmd_valid),
      .pop_ready  (cmd_ready),
      .pop_word   (back_cmd)
   );

   pocx_back u_back (
      .clock     (clock),
      .reset     (reset),
      .n_jobs    (n_jobs),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (back_cmd),
      .rsp_chan  (rsp_chan)
   );

   // input only stalls behind a full queue
   a_stall_needs_queue: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> cmd_valid)
      else $error("input stalled with queue not holding words");

   // a waiting child word holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid && $stable(rsp_chan.payload))
      else $error("child word changed while waiting");

   // the back end takes no queued word while a child word other than the last is pending
   a_no_pop_while_sending: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.payload.last_result |-> !cmd_ready)
      else $error("queue popped during crossover output");

   // effective job count stays in range
   a_jobs_range: assert property (@(posedge clock) disable iff (reset)
      n_jobs >= pocx_pkg::cnt_type'(1) && n_jobs <= pocx_pkg::cnt_type'(pocx_pkg::MAX_JOBS))
      else $error("job count out of range");

endmodule
